// File: hdl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Shared field widths, types and constants for the running temperature
// statistics block.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int TEMP_W  = 7;
    localparam int MEAN_W  = 15;
    localparam int TOTAL_W = 24;

    typedef logic [TEMP_W-1:0]  temp_t;
    typedef logic [MEAN_W-1:0]  mean_t;
    typedef logic [TOTAL_W-1:0] total_t;

    // minimum tracker sentinel before the first accepted sample
    localparam temp_t LOW_RESET = 7'd127;

endpackage

// File: hdl/rts_if.sv
// ----------------------------------------------------------------------------
// rts_if
// Valid/ready channels: temperature samples in, statistics results out.
// ----------------------------------------------------------------------------
interface rts_sample_if;

    logic          valid;
    logic          ready;
    rts_pkg::temp_t temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);

endinterface

interface rts_stats_if;

    logic           valid;
    logic           ready;
    rts_pkg::temp_t  min_temp;
    rts_pkg::temp_t  max_temp;
    rts_pkg::mean_t  mean_q8;
    rts_pkg::temp_t  mode_temp;
    rts_pkg::total_t sample_total;
    logic           rejected;

    modport source (output valid, output min_temp, output max_temp, output mean_q8,
                    output mode_temp, output sample_total, output rejected,
                    input ready);
    modport sink   (input valid, input min_temp, input max_temp, input mean_q8,
                    input mode_temp, input sample_total, input rejected,
                    output ready);

endinterface

// File: hdl/rts_ram.sv
// ----------------------------------------------------------------------------
// rts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 111
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/rts_div.sv
// ----------------------------------------------------------------------------
// rts_div
// Restoring divider, one quotient bit per cycle: (sum << frac) / count.
// The quotient is known to fit TEMP_W + MEAN_FRAC_BITS bits, so only those
// steps are run.
// ----------------------------------------------------------------------------
module rts_div #(
    parameter int COUNT_BITS     = 24,
    parameter int MEAN_FRAC_BITS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [COUNT_BITS+rts_pkg::TEMP_W-1:0]       sum,
    input  logic [COUNT_BITS-1:0]                       count,
    output logic                                        busy,
    output logic [rts_pkg::TEMP_W+MEAN_FRAC_BITS-1:0]   quot
);

    localparam int SUM_W  = COUNT_BITS + rts_pkg::TEMP_W;
    localparam int DW     = SUM_W + MEAN_FRAC_BITS;
    localparam int QB     = rts_pkg::TEMP_W + MEAN_FRAC_BITS;
    localparam int STEP_W = $clog2(QB + 1);

    logic [DW-1:0]         dvd;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [QB-1:0]         q_reg, q_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic [COUNT_BITS+1:0] diff;

    assign dvd  = DW'(sum) << MEAN_FRAC_BITS;
    assign diff = {1'b0, rem_reg, q_reg[QB-1]} - {2'b00, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dvd[DW-1:QB];
            q_next    = dvd[QB-1:0];
            dsr_next  = count;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[COUNT_BITS+1])
            begin
                rem_next = diff[COUNT_BITS-1:0];
                q_next   = {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[COUNT_BITS-2:0], q_reg[QB-1]};
                q_next   = {q_reg[QB-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (32'(step_reg) == QB - 1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// File: hdl/running_temperature_statistics.sv
// ----------------------------------------------------------------------------
// running_temperature_statistics
// Running minimum, maximum, mean, mode and count over temperature samples.
// ----------------------------------------------------------------------------
// One sample at a time; the mean divider works out one quotient bit per
// cycle, and sample.ready stays low until the result is loaded. After reset
// the histogram RAM is swept to zero, all VALUE_SPAN entries (111 by
// default), while sample.ready stays low. A finished result
// sits in an output register, so the next sample is taken while it waits.
module running_temperature_statistics #(
    parameter int VALUE_SPAN     = 111,
    parameter int COUNT_BITS     = 24,
    parameter int MEAN_FRAC_BITS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    rts_sample_if.sink   sample,
    rts_stats_if.source  stats
);

    localparam int IDX_W = $clog2(VALUE_SPAN);
    localparam int SUM_W = COUNT_BITS + rts_pkg::TEMP_W;
    localparam int QB    = rts_pkg::TEMP_W + MEAN_FRAC_BITS;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_START  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;

    rts_pkg::temp_t        t_reg, t_next;
    logic                  rej_reg, rej_next;
    rts_pkg::temp_t        low_reg, low_next;
    rts_pkg::temp_t        high_reg, high_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    rts_pkg::temp_t        mode_reg, mode_next;
    logic [COUNT_BITS-1:0] mode_freq_reg, mode_freq_next;

    logic                  out_valid_reg, out_valid_next;
    rts_pkg::temp_t        out_min_reg, out_min_next;
    rts_pkg::temp_t        out_max_reg, out_max_next;
    rts_pkg::mean_t        out_mean_reg, out_mean_next;
    rts_pkg::temp_t        out_mode_reg, out_mode_next;
    rts_pkg::total_t       out_total_reg, out_total_next;
    logic                  out_rej_reg, out_rej_next;

    logic                  accept;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] bumped;
    logic                  div_start;
    logic                  div_busy;
    logic [QB-1:0]         div_quot;
    logic                  out_load;

    assign accept = sample.valid && sample.ready;
    assign bumped = ram_rdata + 1'b1;

    rts_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (VALUE_SPAN)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (IDX_W'(sample.temperature)),
        .rdata (ram_rdata)
    );

    rts_div #(
        .COUNT_BITS     (COUNT_BITS),
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_reg),
        .count (cnt_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        t_next         = t_reg;
        rej_next       = rej_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        mode_next      = mode_reg;
        mode_freq_next = mode_freq_reg;
        ram_we         = 1'b0;
        ram_waddr      = IDX_W'(t_reg);
        ram_wdata      = bumped;
        div_start      = 1'b0;
        out_load       = 1'b0;
        sample.ready   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == VALUE_SPAN - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                sample.ready = 1'b1;
                if (accept)
                begin
                    t_next   = sample.temperature;
                    rej_next = (32'(sample.temperature) >= VALUE_SPAN) || (&cnt_reg);
                    if ((32'(sample.temperature) >= VALUE_SPAN) || (&cnt_reg))
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                ram_we = 1'b1;
                if (bumped > mode_freq_reg)
                begin
                    mode_freq_next = bumped;
                    mode_next      = t_reg;
                end
                if (cnt_reg == '0)
                begin
                    low_next  = t_reg;
                    high_next = t_reg;
                end
                else
                begin
                    if (t_reg < low_reg)
                    begin
                        low_next = t_reg;
                    end
                    if (t_reg > high_reg)
                    begin
                        high_next = t_reg;
                    end
                end
                cnt_next   = cnt_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(t_reg);
                state_next = S_START;
            end
            S_START:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || stats.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_mean_next  = out_mean_reg;
        out_mode_next  = out_mode_reg;
        out_total_next = out_total_reg;
        out_rej_next   = out_rej_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_total_next = rts_pkg::TOTAL_W'(cnt_reg);
            out_rej_next   = rej_reg;
            if (cnt_reg == '0)
            begin
                out_min_next  = '0;
                out_max_next  = '0;
                out_mean_next = '0;
                out_mode_next = '0;
            end
            else
            begin
                out_min_next  = low_reg;
                out_max_next  = high_reg;
                out_mean_next = rts_pkg::MEAN_W'(div_quot);
                out_mode_next = mode_reg;
            end
        end
        else if (stats.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            low_reg       <= rts_pkg::LOW_RESET;
            high_reg      <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            mode_reg      <= '0;
            mode_freq_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            mode_reg      <= mode_next;
            mode_freq_reg <= mode_freq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        rej_reg       <= rej_next;
        out_min_reg   <= out_min_next;
        out_max_reg   <= out_max_next;
        out_mean_reg  <= out_mean_next;
        out_mode_reg  <= out_mode_next;
        out_total_reg <= out_total_next;
        out_rej_reg   <= out_rej_next;
    end

    assign stats.valid        = out_valid_reg;
    assign stats.min_temp     = out_min_reg;
    assign stats.max_temp     = out_max_reg;
    assign stats.mean_q8      = out_mean_reg;
    assign stats.mode_temp    = out_mode_reg;
    assign stats.sample_total = out_total_reg;
    assign stats.rejected     = out_rej_reg;

    // once anything is accepted the extremes are ordered
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (low_reg <= high_reg))
        else $error("minimum above maximum");

    // the mode's count can never pass the number of accepted samples
    a_mode_freq: assert property (@(posedge clk) disable iff (!rst_n)
        mode_freq_reg <= cnt_reg)
        else $error("mode count exceeds sample count");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // the sample count changes only through a histogram update beat
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(state_reg) == S_UPDATE))
        else $error("sample count moved outside update");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for running_temperature_statistics. Temperature beats
// go in over a valid/ready channel and a predictor works out the expected
// minimum, maximum, Q7.8 mean, mode, count and reject flag for each one. The
// expectations are queued and compared field by field with the result beats.
// A short directed run covers the boundaries, rejects, ties and mode changes.
// Random clustered samples follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
localparam int VALUE_SPAN     = 111;
localparam int COUNT_BITS     = 24;
localparam int MEAN_FRAC_BITS = 8;

typedef struct packed {
    rts_pkg::temp_t  min_temp;
    rts_pkg::temp_t  max_temp;
    rts_pkg::mean_t  mean_q8;
    rts_pkg::temp_t  mode_temp;
    rts_pkg::total_t sample_total;
    logic            rejected;
} stats_beat_t;

class temp_stats_tracker;

    bit [COUNT_BITS-1:0] histogram [VALUE_SPAN];
    rts_pkg::temp_t      lowest;
    rts_pkg::temp_t      highest;
    rts_pkg::temp_t      mode_value;
    bit [COUNT_BITS-1:0] mode_count;
    bit [COUNT_BITS-1:0] sample_count;
    longint unsigned     temp_sum;
    stats_beat_t         awaited_stats [$];
    int                  failures;
    int                  samples_taken;
    int                  samples_refused;
    int                  beats_checked;

    function new();
        foreach (histogram[i])
            histogram[i] = '0;
        lowest          = rts_pkg::LOW_RESET;
        highest         = '0;
        mode_value      = '0;
        mode_count      = '0;
        sample_count    = '0;
        temp_sum        = 0;
        failures        = 0;
        samples_taken   = 0;
        samples_refused = 0;
        beats_checked   = 0;
    endfunction

    function void take_sample(rts_pkg::temp_t t);
        stats_beat_t       stats;
        logic              refuse;
        bit [COUNT_BITS:0] bumped;
        longint unsigned   scaled;
        refuse = (t >= VALUE_SPAN) || (&sample_count);
        if (!refuse)
        begin
            bumped       = histogram[t] + 1'b1;
            histogram[t] = bumped[COUNT_BITS-1:0];
            if (bumped > mode_count)
            begin
                mode_count = bumped[COUNT_BITS-1:0];
                mode_value = t;
            end
            if (sample_count == 0)
            begin
                lowest  = t;
                highest = t;
            end
            else
            begin
                if (t < lowest)
                    lowest = t;
                if (t > highest)
                    highest = t;
            end
            sample_count = sample_count + 1'b1;
            temp_sum     = temp_sum + t;
        end
        stats = '0;
        if (sample_count != 0)
        begin
            scaled          = (temp_sum << MEAN_FRAC_BITS) / sample_count;
            stats.min_temp  = lowest;
            stats.max_temp  = highest;
            stats.mode_temp = mode_value;
            stats.mean_q8   = scaled[rts_pkg::MEAN_W-1:0];
        end
        stats.sample_total = sample_count[rts_pkg::TOTAL_W-1:0];
        stats.rejected     = refuse;
        samples_taken++;
        if (refuse)
            samples_refused++;
        awaited_stats.push_back(stats);
    endfunction

    function void compare_result(stats_beat_t got);
        stats_beat_t want;
        if (awaited_stats.size() == 0)
        begin
            $error("stats beat with no sample outstanding");
            failures++;
            return;
        end
        want = awaited_stats.pop_front();
        beats_checked++;
        if (got.min_temp !== want.min_temp)
        begin
            $error("min_temp: expected %0d, got %0d", want.min_temp, got.min_temp);
            failures++;
        end
        if (got.max_temp !== want.max_temp)
        begin
            $error("max_temp: expected %0d, got %0d", want.max_temp, got.max_temp);
            failures++;
        end
        if (got.mean_q8 !== want.mean_q8)
        begin
            $error("mean_q8: expected %0d, got %0d", want.mean_q8, got.mean_q8);
            failures++;
        end
        if (got.mode_temp !== want.mode_temp)
        begin
            $error("mode_temp: expected %0d, got %0d", want.mode_temp, got.mode_temp);
            failures++;
        end
        if (got.sample_total !== want.sample_total)
        begin
            $error("sample_total: expected %0d, got %0d", want.sample_total,
                   got.sample_total);
            failures++;
        end
        if (got.rejected !== want.rejected)
        begin
            $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
            failures++;
        end
    endfunction

endclass

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_SAMPLES = 1250;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int OPENING_LEN    = 20;
    // rejects before any accept, first sample, tie keeps earlier mode, bit patterns
    localparam int OPENING_TEMPS [OPENING_LEN] = '{
        127, 111, 110, 0, 0, 110, 110, 64, 63, 1,
        109, 120, 85, 42, 42, 42, 42, 127, 2, 111
    };

    logic clk;
    logic rst_n;
    bit   steady;
    int   idle_cycles;

    rts_sample_if sample_ch ();
    rts_stats_if  stats_ch ();

    temp_stats_tracker tracker;

    running_temperature_statistics #(
        .VALUE_SPAN     (VALUE_SPAN),
        .COUNT_BITS     (COUNT_BITS),
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .stats  (stats_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic rts_pkg::temp_t pick_temperature(int base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return rts_pkg::temp_t'($urandom_range(VALUE_SPAN, 127));
        if (r < 52)
            return rts_pkg::temp_t'(base + $urandom_range(0, 4));
        return rts_pkg::temp_t'($urandom_range(0, VALUE_SPAN - 1));
    endfunction

    // called at a rising edge; returns at the edge that accepts the beat
    task automatic send_sample(rts_pkg::temp_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.temperature <= t;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    initial
    begin
        stats_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int gap;
            gap = pick_gap();
            if (gap > 0)
            begin
                stats_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            stats_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        stats_beat_t got;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                tracker.take_sample(sample_ch.temperature);
            if (stats_ch.valid && stats_ch.ready)
            begin
                got.min_temp     = stats_ch.min_temp;
                got.max_temp     = stats_ch.max_temp;
                got.mean_q8      = stats_ch.mean_q8;
                got.mode_temp    = stats_ch.mode_temp;
                got.sample_total = stats_ch.sample_total;
                got.rejected     = stats_ch.rejected;
                tracker.compare_result(got);
            end
        end
    end

    // watchdog: cycles without a beat on either channel
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (stats_ch.valid && stats_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d results outstanding",
                     idle_cycles, tracker.awaited_stats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int base;
        int run_len;
        tracker               = new();
        idle_cycles           = 0;
        steady                = 1'b0;
        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.temperature <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING_TEMPS[i])
            send_sample(rts_pkg::temp_t'(OPENING_TEMPS[i]));

        sent = 0;
        while (sent < RANDOM_SAMPLES)
        begin
            base    = $urandom_range(0, VALUE_SPAN - 5);
            steady  = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(20, 80);
            repeat (run_len)
            begin
                send_sample(pick_temperature(base));
                sent++;
            end
        end
        steady          = 1'b0;
        sample_ch.valid <= 1'b0;

        while (tracker.awaited_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d temperature beats, %0d refused, %0d result beats checked",
                 tracker.samples_taken, tracker.samples_refused, tracker.beats_checked);
        $display("Final count %0d, min %0d, max %0d, mode %0d",
                 tracker.sample_count, tracker.lowest, tracker.highest,
                 tracker.mode_value);
        if (tracker.failures == 0 && tracker.awaited_stats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
